// File: rtl/core/csr_pkg.sv
`default_nettype none
package csr_pkg;

    localparam int SLOTS_DEF      = 4;
    localparam int SLOT_BYTES_DEF = 512;

    localparam logic [7:0] TIMEOUT_RESET   = 8'd5;
    localparam logic       REG_TIMEOUT_IDX = 1'b0;

    localparam logic       OP_TICK    = 1'b1;
    localparam logic [1:0] SEG_SINGLE = 2'd0;
    localparam logic [1:0] SEG_FIRST  = 2'd1;
    localparam logic [1:0] SEG_MIDDLE = 2'd2;

    localparam logic [1:0] KIND_SINGLE  = 2'd0;
    localparam logic [1:0] KIND_CHUNK   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [31:0] msg_id;
        logic [1:0]  seg_kind;
        logic [7:0]  seg_num;
        logic [2:0]  data_len;
        logic [7:0]  byte_0;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [7:0]  byte_4;
        logic [7:0]  byte_5;
        logic [7:0]  byte_6;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] result_id;
        logic [3:0]  byte_count;
        logic [7:0]  out_byte_0;
        logic [7:0]  out_byte_1;
        logic [7:0]  out_byte_2;
        logic [7:0]  out_byte_3;
        logic [7:0]  out_byte_4;
        logic [7:0]  out_byte_5;
        logic [7:0]  out_byte_6;
        logic [7:0]  out_byte_7;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        CLS_TICK,
        CLS_SINGLE,
        CLS_FIRST,
        CLS_MIDDLE,
        CLS_FINAL
    } cls_t;

    typedef struct packed {
        cls_t            cls;
        logic [31:0]     msg_id;
        logic [7:0]      seg_num;
        logic [2:0]      data_len;
        logic [6:0][7:0] data;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLAIM,
        S_WRITE,
        S_CHUNK,
        S_RD,
        S_CAP,
        S_TICK,
        S_EMIT
    } state_t;

    typedef struct packed {
        state_t state;
        logic   push;
        logic   tick_cmd;
    } eng_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/csr_ram.sv
`default_nettype none
module csr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [AW-1:0]            raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/csr_front.sv
`default_nettype none
module csr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire csr_pkg::in_item_t in_data,
    output logic                   cmd_valid,
    output csr_pkg::cmd_t          cmd,
    input  wire logic              cmd_pop
);
    csr_pkg::cmd_t ent_reg [2];
    logic          wptr_reg, wptr_next;
    logic          rptr_reg, rptr_next;
    logic [1:0]    count_reg, count_next;
    csr_pkg::cmd_t cls_cmd;
    logic          push;

    // classify the item
    always_comb
    begin
        cls_cmd.msg_id   = in_data.msg_id;
        cls_cmd.seg_num  = in_data.seg_num;
        cls_cmd.data_len = in_data.data_len;
        cls_cmd.data     = {in_data.byte_6, in_data.byte_5, in_data.byte_4, in_data.byte_3,
                            in_data.byte_2, in_data.byte_1, in_data.byte_0};
        if (in_data.operation == csr_pkg::OP_TICK)
        begin
            cls_cmd.cls = csr_pkg::CLS_TICK;
        end
        else
        begin
            case (in_data.seg_kind)
                csr_pkg::SEG_SINGLE: cls_cmd.cls = csr_pkg::CLS_SINGLE;
                csr_pkg::SEG_FIRST:  cls_cmd.cls = csr_pkg::CLS_FIRST;
                csr_pkg::SEG_MIDDLE: cls_cmd.cls = csr_pkg::CLS_MIDDLE;
                default:             cls_cmd.cls = csr_pkg::CLS_FINAL;
            endcase
        end
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ cmd_pop;
        count_next = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= cls_cmd;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/csr_engine.sv
`default_nettype none
module csr_engine #(
    parameter int SLOTS      = csr_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = csr_pkg::SLOT_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         timeout_ticks,
    input  wire logic               cmd_valid,
    input  wire csr_pkg::cmd_t      cmd,
    output logic                    cmd_pop,
    output logic                    res_push,
    output csr_pkg::out_item_t      res_item,
    input  wire logic               res_space,
    output csr_pkg::eng_stat_t      stat
);
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH = SLOTS * SLOT_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [31:0]      id_reg    [SLOTS];
    logic [31:0]      id_next   [SLOTS];
    logic [LEN_W-1:0] len_reg   [SLOTS];
    logic [LEN_W-1:0] len_next  [SLOTS];
    logic [7:0]       nseg_reg  [SLOTS];
    logic [7:0]       nseg_next [SLOTS];
    logic [7:0]       timer_reg [SLOTS];
    logic [7:0]       timer_next[SLOTS];

    csr_pkg::state_t    state_reg, state_next;
    csr_pkg::state_t    ret_reg, ret_next;
    csr_pkg::cmd_t      cmd_reg, cmd_next;
    csr_pkg::out_item_t res_reg, res_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [2:0]         wpos_reg, wpos_next;
    logic [LEN_W-1:0]   wbase_reg, wbase_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic [LEN_W-1:0]   rpos_reg, rpos_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [3:0]         j_reg, j_next;
    logic [7:0][7:0]    chunk_reg, chunk_next;
    logic [SLOTS-1:0]   tmask_reg, tmask_next;

    logic             hit, free_ok;
    logic [SW-1:0]    hit_idx, free_idx, tick_idx;
    logic [7:0][7:0]  sbytes;
    logic [7:0]       tinc;
    logic [LEN_W-1:0] rem;
    logic [LEN_W:0]   newlen;
    logic [AW-1:0]    base;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    function automatic csr_pkg::out_item_t mk(logic [1:0] k, logic [31:0] id, logic [3:0] c,
                                              logic [7:0][7:0] b, logic l);
        csr_pkg::out_item_t r;
        r.kind       = k;
        r.result_id  = id;
        r.byte_count = c;
        r.out_byte_0 = b[0];
        r.out_byte_1 = b[1];
        r.out_byte_2 = b[2];
        r.out_byte_3 = b[3];
        r.out_byte_4 = b[4];
        r.out_byte_5 = b[5];
        r.out_byte_6 = b[6];
        r.out_byte_7 = b[7];
        r.last       = l;
        return r;
    endfunction

    csr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot lookup, lowest index wins
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        tick_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (busy_reg[s] && id_reg[s] == cmd_reg.msg_id)
            begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!busy_reg[s])
            begin
                free_ok  = 1'b1;
                free_idx = SW'(s);
            end
            if (tmask_reg[s])
            begin
                tick_idx = SW'(s);
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            sbytes[i] = (i < 7 && 3'(i) < cmd_reg.data_len) ? cmd_reg.data[i] : 8'd0;
        end
    end

    assign base      = AW'(slot_reg) * AW'(SLOT_BYTES);
    assign ram_waddr = base + AW'(wbase_reg) + AW'(wpos_reg);
    assign ram_raddr = base + AW'(rpos_reg) + AW'(j_reg);
    assign ram_wdata = (wpos_reg == 3'd7) ? 8'd0 : cmd_reg.data[wpos_reg];
    assign res_item  = res_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        nseg_next  = nseg_reg;
        timer_next = timer_reg;
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        slot_next  = slot_reg;
        wpos_next  = wpos_reg;
        wbase_next = wbase_reg;
        total_next = total_reg;
        rpos_next  = rpos_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        chunk_next = chunk_reg;
        tmask_next = tmask_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        ram_we     = 1'b0;
        tinc       = 8'd0;
        rem        = total_reg - rpos_reg;
        newlen     = '0;

        case (state_reg)
            csr_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    cmd_pop    = 1'b1;
                    state_next = csr_pkg::S_DECODE;
                end
            end
            csr_pkg::S_DECODE:
            begin
                case (cmd_reg.cls)
                    csr_pkg::CLS_TICK:
                    begin
                        for (int s = 0; s < SLOTS; s++)
                        begin
                            tmask_next[s] = 1'b0;
                            if (busy_reg[s])
                            begin
                                tinc = (timer_reg[s] == 8'hff) ? 8'hff : timer_reg[s] + 8'd1;
                                if (tinc >= timeout_ticks)
                                begin
                                    tmask_next[s] = 1'b1;
                                    busy_next[s]  = 1'b0;
                                    timer_next[s] = 8'd0;
                                end
                                else
                                begin
                                    timer_next[s] = tinc;
                                end
                            end
                        end
                        state_next = csr_pkg::S_TICK;
                    end
                    csr_pkg::CLS_SINGLE:
                    begin
                        res_next   = mk(csr_pkg::KIND_SINGLE, cmd_reg.msg_id,
                                        {1'b0, cmd_reg.data_len}, sbytes, 1'b1);
                        ret_next   = csr_pkg::S_IDLE;
                        state_next = csr_pkg::S_EMIT;
                    end
                    csr_pkg::CLS_FIRST:
                    begin
                        if (hit)
                        begin
                            busy_next[hit_idx]  = 1'b0;
                            timer_next[hit_idx] = 8'd0;
                            res_next   = mk(csr_pkg::KIND_ERROR, cmd_reg.msg_id, 4'd0, '0, 1'b1);
                            ret_next   = csr_pkg::S_CLAIM;
                            state_next = csr_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = csr_pkg::S_CLAIM;
                        end
                    end
                    default:
                    begin
                        newlen = {1'b0, len_reg[hit_idx]} + (LEN_W + 1)'(cmd_reg.data_len);
                        if (!hit)
                        begin
                            state_next = csr_pkg::S_IDLE;
                        end
                        else if (cmd_reg.seg_num != nseg_reg[hit_idx] ||
                                 newlen > (LEN_W + 1)'(SLOT_BYTES))
                        begin
                            busy_next[hit_idx]  = 1'b0;
                            timer_next[hit_idx] = 8'd0;
                            res_next   = mk(csr_pkg::KIND_ERROR, cmd_reg.msg_id, 4'd0, '0, 1'b1);
                            ret_next   = csr_pkg::S_IDLE;
                            state_next = csr_pkg::S_EMIT;
                        end
                        else
                        begin
                            slot_next  = hit_idx;
                            wbase_next = len_reg[hit_idx];
                            wpos_next  = 3'd0;
                            len_next[hit_idx] = newlen[LEN_W-1:0];
                            total_next = newlen[LEN_W-1:0];
                            timer_next[hit_idx] = 8'd0;
                            if (cmd_reg.cls == csr_pkg::CLS_MIDDLE)
                            begin
                                nseg_next[hit_idx] = nseg_reg[hit_idx] + 8'd1;
                            end
                            else
                            begin
                                busy_next[hit_idx] = 1'b0;
                            end
                            state_next = csr_pkg::S_WRITE;
                        end
                    end
                endcase
            end
            csr_pkg::S_CLAIM:
            begin
                if (free_ok)
                begin
                    busy_next[free_idx]  = 1'b1;
                    id_next[free_idx]    = cmd_reg.msg_id;
                    len_next[free_idx]   = LEN_W'(cmd_reg.data_len);
                    nseg_next[free_idx]  = 8'd1;
                    timer_next[free_idx] = 8'd0;
                    slot_next  = free_idx;
                    wbase_next = '0;
                    wpos_next  = 3'd0;
                    state_next = csr_pkg::S_WRITE;
                end
                else
                begin
                    state_next = csr_pkg::S_IDLE;
                end
            end
            csr_pkg::S_WRITE:
            begin
                if (wpos_reg == cmd_reg.data_len)
                begin
                    rpos_next  = '0;
                    state_next = (cmd_reg.cls == csr_pkg::CLS_FINAL) ? csr_pkg::S_CHUNK
                                                                     : csr_pkg::S_IDLE;
                end
                else
                begin
                    ram_we    = 1'b1;
                    wpos_next = wpos_reg + 3'd1;
                end
            end
            csr_pkg::S_CHUNK:
            begin
                cnt_next   = (rem > LEN_W'(8)) ? 4'd8 : rem[3:0];
                j_next     = 4'd0;
                chunk_next = '0;
                if (rem == '0)
                begin
                    res_next   = mk(csr_pkg::KIND_CHUNK, cmd_reg.msg_id, 4'd0, '0, 1'b1);
                    ret_next   = csr_pkg::S_IDLE;
                    state_next = csr_pkg::S_EMIT;
                end
                else
                begin
                    state_next = csr_pkg::S_RD;
                end
            end
            csr_pkg::S_RD:
            begin
                state_next = csr_pkg::S_CAP;
            end
            csr_pkg::S_CAP:
            begin
                chunk_next[j_reg[2:0]] = ram_rdata;
                j_next = j_reg + 4'd1;
                if (j_next == cnt_reg)
                begin
                    rpos_next  = rpos_reg + LEN_W'(cnt_reg);
                    res_next   = mk(csr_pkg::KIND_CHUNK, cmd_reg.msg_id, cnt_reg, chunk_next,
                                    rpos_next == total_reg);
                    ret_next   = (rpos_next == total_reg) ? csr_pkg::S_IDLE : csr_pkg::S_CHUNK;
                    state_next = csr_pkg::S_EMIT;
                end
                else
                begin
                    state_next = csr_pkg::S_RD;
                end
            end
            csr_pkg::S_TICK:
            begin
                if (tmask_reg == '0)
                begin
                    state_next = csr_pkg::S_IDLE;
                end
                else
                begin
                    tmask_next[tick_idx] = 1'b0;
                    res_next   = mk(csr_pkg::KIND_TIMEOUT, id_reg[tick_idx], 4'd0, '0,
                                    tmask_next == '0);
                    ret_next   = csr_pkg::S_TICK;
                    state_next = csr_pkg::S_EMIT;
                end
            end
            csr_pkg::S_EMIT:
            begin
                if (res_space)
                begin
                    res_push   = 1'b1;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = csr_pkg::S_IDLE;
            end
        endcase
    end

    assign stat.state    = state_reg;
    assign stat.push     = res_push;
    assign stat.tick_cmd = (cmd_reg.cls == csr_pkg::CLS_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csr_pkg::S_IDLE;
            busy_reg  <= '0;
            tmask_reg <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                len_reg[s]   <= '0;
                nseg_reg[s]  <= 8'd0;
                timer_reg[s] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            tmask_reg <= tmask_next;
            len_reg   <= len_next;
            nseg_reg  <= nseg_next;
            timer_reg <= timer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        ret_reg   <= ret_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        slot_reg  <= slot_next;
        wpos_reg  <= wpos_next;
        wbase_reg <= wbase_next;
        total_reg <= total_next;
        rpos_reg  <= rpos_next;
        cnt_reg   <= cnt_next;
        j_reg     <= j_next;
        chunk_reg <= chunk_next;
    end
endmodule
`default_nettype wire

// File: rtl/core/can_segment_reassembly.sv
`default_nettype none
// channel   direction  handshake                  payload
// in        input      in_valid / in_ready        in_data   (csr_pkg::in_item_t)
// out       output     out_valid / out_ready      out_data  (csr_pkg::out_item_t)
// apb       input      psel penable pwrite pready paddr pwdata prdata
//
// a middle or last segment is written to its slot byte by byte, a first segment
// claims a free slot first; a single frame goes straight out; a tick emits one
// timeout notice per expired slot; a completed message is read back byte by byte,
// each read captured before the next, and sent in chunks of up to 8 bytes
// a two-entry input queue accepts items while the engine or output stalls, until full
// reset frees all slots and sets timeout_ticks to 5; no clearing pass
module can_segment_reassembly #(
    parameter int SLOTS      = csr_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = csr_pkg::SLOT_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire csr_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output csr_pkg::out_item_t      out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [7:0]         timeout_reg;
    logic               out_valid_reg;
    csr_pkg::out_item_t out_data_reg;
    logic               cmd_valid, cmd_pop, res_push, res_space;
    csr_pkg::cmd_t      cmd;
    csr_pkg::out_item_t res_item;
    csr_pkg::eng_stat_t stat;

    assign pready    = 1'b1;
    assign prdata    = {24'd0, timeout_reg};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign res_space = !out_valid_reg || out_ready;

    csr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    csr_engine #(.SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .res_push      (res_push),
        .res_item      (res_item),
        .res_space     (res_space),
        .stat          (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= csr_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == csr_pkg::REG_TIMEOUT_IDX)
            begin
                timeout_reg <= pwdata[7:0];
            end
            if (res_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_data_reg <= res_item;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed into a full output register");

    a_timeout_src: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.push && res_item.kind == csr_pkg::KIND_TIMEOUT) |-> stat.tick_cmd)
        else $error("timeout notice outside a tick");

    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.push |-> stat.state == csr_pkg::S_EMIT)
        else $error("result pushed outside emit");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT    = csr_pkg::SLOTS_DEF;
    localparam int NBYTES   = csr_pkg::SLOT_BYTES_DEF;
    localparam int WD_LIMIT = 40000;
    localparam int DRAIN    = 2500;
    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
    localparam logic       OP_FRAME = 1'b0;
    localparam logic [1:0] SEG_LAST = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    csr_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    csr_pkg::out_item_t out_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    can_segment_reassembly dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [7:0]  tmo_ticks;
    logic        busy_q [NSLOT];
    logic [31:0] id_q   [NSLOT];
    logic [9:0]  len_q  [NSLOT];
    logic [7:0]  nseg_q [NSLOT];
    logic [7:0]  tmr_q  [NSLOT];
    logic [7:0]  mem_q  [NSLOT][NBYTES];

    csr_pkg::out_item_t pending_results[$];
    int  n_errors = 0;
    int  idle_cycles = 0;
    bit  no_stall = 0;
    bit  timed_out = 0;

    function automatic csr_pkg::out_item_t make_result(logic [1:0] k, logic [31:0] id,
                                                       int cnt, logic [7:0] b [8]);
        csr_pkg::out_item_t r;
        logic [7:0] v [8];
        for (int i = 0; i < 8; i++)
            v[i] = (i < cnt) ? b[i] : 8'd0;
        r.kind = k;
        r.result_id = id;
        r.byte_count = 4'(cnt);
        r.out_byte_0 = v[0]; r.out_byte_1 = v[1]; r.out_byte_2 = v[2];
        r.out_byte_3 = v[3]; r.out_byte_4 = v[4]; r.out_byte_5 = v[5];
        r.out_byte_6 = v[6]; r.out_byte_7 = v[7];
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_reassembly(input csr_pkg::in_item_t it);
        csr_pkg::out_item_t res[$];
        csr_pkg::out_item_t r;
        logic [7:0] b [8];
        logic [7:0] z [8];
        int s, fs, pos, c, total, len;
        for (int i = 0; i < 8; i++)
            z[i] = 8'd0;
        b[0] = it.byte_0; b[1] = it.byte_1; b[2] = it.byte_2; b[3] = it.byte_3;
        b[4] = it.byte_4; b[5] = it.byte_5; b[6] = it.byte_6; b[7] = 8'd0;
        len = it.data_len;
        if (it.operation == csr_pkg::OP_TICK) begin
            for (s = 0; s < NSLOT; s++) begin
                if (busy_q[s]) begin
                    if (tmr_q[s] < 8'd255)
                        tmr_q[s]++;
                    if (tmr_q[s] >= tmo_ticks) begin
                        res.push_back(make_result(csr_pkg::KIND_TIMEOUT, id_q[s], 0, z));
                        busy_q[s] = 0;
                        tmr_q[s] = 0;
                    end
                end
            end
        end else begin
            fs = NSLOT;
            for (s = NSLOT - 1; s >= 0; s--)
                if (busy_q[s] && id_q[s] == it.msg_id)
                    fs = s;
            if (it.seg_kind == csr_pkg::SEG_SINGLE) begin
                res.push_back(make_result(csr_pkg::KIND_SINGLE, it.msg_id, len, b));
            end else if (it.seg_kind == csr_pkg::SEG_FIRST) begin
                if (fs < NSLOT) begin
                    res.push_back(make_result(csr_pkg::KIND_ERROR, it.msg_id, 0, z));
                    busy_q[fs] = 0;
                    tmr_q[fs] = 0;
                end
                for (s = 0; s < NSLOT; s++)
                    if (!busy_q[s])
                        break;
                if (s < NSLOT) begin
                    busy_q[s] = 1;
                    id_q[s] = it.msg_id;
                    for (int i = 0; i < len; i++)
                        mem_q[s][i] = b[i];
                    len_q[s] = 10'(len);
                    nseg_q[s] = 8'd1;
                    tmr_q[s] = 8'd0;
                end
            end else if (fs < NSLOT) begin
                s = fs;
                if (it.seg_num != nseg_q[s] || int'(len_q[s]) + len > NBYTES) begin
                    res.push_back(make_result(csr_pkg::KIND_ERROR, it.msg_id, 0, z));
                    busy_q[s] = 0;
                    tmr_q[s] = 0;
                end else begin
                    for (int i = 0; i < len; i++)
                        mem_q[s][int'(len_q[s]) + i] = b[i];
                    len_q[s] = len_q[s] + 10'(len);
                    if (it.seg_kind == csr_pkg::SEG_MIDDLE) begin
                        nseg_q[s] = nseg_q[s] + 8'd1;
                        tmr_q[s] = 8'd0;
                    end else begin
                        total = len_q[s];
                        pos = 0;
                        do begin
                            c = total - pos;
                            if (c > 8)
                                c = 8;
                            for (int i = 0; i < 8; i++)
                                b[i] = (i < c) ? mem_q[s][pos + i] : 8'd0;
                            res.push_back(make_result(csr_pkg::KIND_CHUNK, it.msg_id, c, b));
                            pos += c;
                        end while (pos < total);
                        busy_q[s] = 0;
                        tmr_q[s] = 0;
                    end
                end
            end
        end
        for (int i = 0; i < res.size(); i++) begin
            r = res[i];
            r.last = (i == res.size() - 1);
            pending_results.push_back(r);
        end
    endtask

    task automatic send_item(input csr_pkg::in_item_t it);
        if (!no_stall && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_reassembly(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_TIMEOUT;
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tmo_ticks = (v == 8'd0) ? 8'd1 : v;
    endtask

    function automatic csr_pkg::in_item_t rand_frame(logic [1:0] k, logic [31:0] id,
                                                     logic [7:0] sn, int len);
        csr_pkg::in_item_t it;
        it = {$urandom, $urandom, $urandom, 6'($urandom)};
        it.operation = OP_FRAME;
        it.msg_id = id;
        it.seg_kind = k;
        it.seg_num = sn;
        it.data_len = 3'(len);
        return it;
    endfunction

    function automatic csr_pkg::in_item_t tick_item();
        csr_pkg::in_item_t it;
        it = {$urandom, $urandom, $urandom, 6'($urandom)};
        it.operation = csr_pkg::OP_TICK;
        return it;
    endfunction

    task automatic send_message(input logic [31:0] id, input int nmid, input bit full);
        send_item(rand_frame(csr_pkg::SEG_FIRST, id, 8'($urandom),
                             full ? 7 : $urandom_range(0, 7)));
        for (int i = 1; i <= nmid; i++)
            send_item(rand_frame(csr_pkg::SEG_MIDDLE, id, 8'(i),
                                 full ? 7 : $urandom_range(0, 7)));
        send_item(rand_frame(SEG_LAST, id, 8'(nmid + 1), full ? 7 : $urandom_range(0, 7)));
    endtask

    task automatic test_directed();
        csr_pkg::in_item_t it;
        it = rand_frame(csr_pkg::SEG_SINGLE, 32'hFFFF_FFFF, 8'hFF, 7);
        it.byte_0 = 8'hFF; it.byte_6 = 8'hFF;
        send_item(it);
        send_item(rand_frame(csr_pkg::SEG_SINGLE, 32'd0, 8'd0, 0));
        send_message(32'h0000_0010, 2, 1);
        // empty message
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h20, 8'd0, 0));
        send_item(rand_frame(SEG_LAST, 32'h20, 8'd1, 0));
        // wrong number
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h30, 8'd0, 3));
        send_item(rand_frame(csr_pkg::SEG_MIDDLE, 32'h30, 8'd5, 3));
        // no matching slot
        send_item(rand_frame(csr_pkg::SEG_MIDDLE, 32'h31, 8'd1, 3));
        send_item(rand_frame(SEG_LAST, 32'h31, 8'd1, 3));
        // id already in progress
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h40, 8'd0, 2));
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h40, 8'd0, 2));
        // slots full, with 0x40 still held: the last of these and the next first segment are dropped
        for (int i = 0; i < NSLOT; i++)
            send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h50 + i, 8'd0, 1));
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h60, 8'd0, 1));
        // timeout
        for (int i = 0; i < 6; i++)
            send_item(tick_item());
    endtask

    task automatic test_overflow();
        // 74 x 7 bytes passes 512
        write_timeout(8'd255);
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'hA5A5_0001, 8'd0, 7));
        for (int i = 1; i < 74; i++)
            send_item(rand_frame(csr_pkg::SEG_MIDDLE, 32'hA5A5_0001, 8'(i), 7));
    endtask

    task automatic test_timeout_setting(input logic [7:0] v);
        write_timeout(v);
        send_item(rand_frame(csr_pkg::SEG_FIRST, 32'h7000 + v, 8'd0, 4));
        for (int i = 0; i < 8; i++)
            send_item(tick_item());
    endtask

    task automatic test_random(input int n);
        logic [31:0] ids [6];
        logic [7:0]  nxt [6];
        int r, k;
        for (int i = 0; i < 6; i++)
        begin
            ids[i] = $urandom;
            nxt[i] = 8'd0;
        end
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 5);
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(tick_item());
            else if (r < 15)
                send_item(rand_frame(csr_pkg::SEG_SINGLE, $urandom, 8'($urandom),
                                     $urandom_range(0, 7)));
            else if (r < 20)
                send_item(rand_frame(2'($urandom), $urandom, 8'($urandom),
                                     $urandom_range(0, 7)));
            else if (r < 35 || nxt[k] == 0) begin
                send_item(rand_frame(csr_pkg::SEG_FIRST, ids[k], 8'($urandom),
                                     $urandom_range(0, 7)));
                nxt[k] = 8'd1;
            end else if (r < 80) begin
                send_item(rand_frame(csr_pkg::SEG_MIDDLE, ids[k],
                                     ($urandom_range(0, 15) == 0) ? 8'($urandom) : nxt[k],
                                     $urandom_range(0, 7)));
                nxt[k]++;
            end else begin
                send_item(rand_frame(SEG_LAST, ids[k], ($urandom_range(0, 15) == 0) ?
                                     8'($urandom) : nxt[k], $urandom_range(0, 7)));
                nxt[k] = 8'd0;
            end
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %h", out_data);
            end else begin
                csr_pkg::out_item_t e;
                e = pending_results.pop_front();
                if (e !== out_data) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %h actual %h", e, out_data);
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        int gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (no_stall)
                out_ready <= 1'b1;
            else if (gap > 0) begin
                gap--;
                out_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        tmo_ticks = csr_pkg::TIMEOUT_RESET;
        for (int s = 0; s < NSLOT; s++)
        begin
            busy_q[s] = 0; id_q[s] = '0; len_q[s] = '0; nseg_q[s] = '0; tmr_q[s] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_timeout_setting(8'd0);
        test_timeout_setting(8'd1);
        test_timeout_setting(8'd3);
        write_timeout(8'd4);
        test_random(100);
        write_timeout(csr_pkg::TIMEOUT_RESET);
        no_stall = 1;
        test_random(25);
        wait_idle();
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
